### hdl/bcc_pkg.sv
// Shared types and constants for the bubble collapsing conveyor.
// Used by the channel interfaces and every conveyor module; no dependencies.
package bcc_pkg;

   localparam int MAX_SLOTS      = 16;
   localparam int ID_WIDTH       = 8;
   localparam int LEN_WIDTH      = 5;
   localparam int CMD_WIDTH      = 2;
   localparam int COUNT_WIDTH    = $clog2(MAX_SLOTS + 1);
   localparam int SLOT_IDX_WIDTH = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int RESET_LENGTH   = (16 <= MAX_SLOTS) ? 16 : MAX_SLOTS;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_INSERT   = 2'd0,
      CMD_ADVANCE  = 2'd1,
      CMD_RETRIEVE = 2'd2
   } cmd_type;

   // one request transaction held in the input register
   typedef struct packed {
      logic                 valid;
      logic [CMD_WIDTH-1:0] command;
      logic [ID_WIDTH-1:0]  package_id;
   } item_type;

   // one response transaction
   typedef struct packed {
      logic                   success;
      logic [ID_WIDTH-1:0]    retrieved_id;
      logic                   exit_occupied;
      logic [COUNT_WIDTH-1:0] occupied_count;
   } result_type;

endpackage

### hdl/bcc_req_if.sv
// Request channel of the conveyor: valid/ready plus command and package id.
// Depends on bcc_pkg for the field widths.
interface bcc_req_if;
   logic                          valid;
   logic                          ready;
   logic [bcc_pkg::CMD_WIDTH-1:0] command;
   logic [bcc_pkg::ID_WIDTH-1:0]  package_id;

   modport source (output valid, output command, output package_id, input ready);
   modport sink   (input valid, input command, input package_id, output ready);
endinterface

### hdl/bcc_rsp_if.sv
// Response channel of the conveyor: valid/ready plus the result fields.
// Depends on bcc_pkg for the field widths.
interface bcc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            success;
   logic [bcc_pkg::ID_WIDTH-1:0]    retrieved_id;
   logic                            exit_occupied;
   logic [bcc_pkg::COUNT_WIDTH-1:0] occupied_count;

   modport source (output valid, output success, output retrieved_id,
                   output exit_occupied, output occupied_count, input ready);
   modport sink   (input valid, input success, input retrieved_id,
                   input exit_occupied, input occupied_count, output ready);
endinterface

### hdl/bubble_collapsing_conveyor.sv
// Bubble collapsing conveyor, top level.
// A request is held in the input register until the result register has room, then its response is held there.
// Throughput: one transaction per cycle while the response channel takes results; set by the
// single-pass belt update between the input register and the result register.
// Reset: synchronous, empties every slot, sets belt length to 16, drops held transactions.
// Depends on bcc_pkg, bcc_req_if, bcc_rsp_if and the three bcc_ stage modules.
module bubble_collapsing_conveyor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bcc_pkg::LEN_WIDTH-1:0] csr_wdata,
   bcc_req_if.sink                       req_ch,
   bcc_rsp_if.source                     rsp_ch
);

   bcc_pkg::item_type   item;
   bcc_pkg::result_type result;
   logic                can_push;
   logic                fire;

   // move the held request into the result register when there is room
   assign fire = item.valid && can_push;

   bcc_input_stage u_input (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .pop    (fire),
      .item   (item)
   );

   bcc_belt u_belt (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .fire      (fire),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   bcc_output_stage u_output (
      .clock    (clock),
      .reset    (reset),
      .push     (fire),
      .result   (result),
      .can_push (can_push),
      .rsp_ch   (rsp_ch)
   );

endmodule

### hdl/bcc_input_stage.sv
// Input register of the conveyor: captures one request transaction.
// Depends on bcc_pkg and bcc_req_if.
module bcc_input_stage (
   input  logic              clock,
   input  logic              reset,
   bcc_req_if.sink           req_ch,
   input  logic              pop,
   output bcc_pkg::item_type item
);

   logic                          valid_ff, valid_in;
   logic [bcc_pkg::CMD_WIDTH-1:0] command_ff;
   logic [bcc_pkg::ID_WIDTH-1:0]  package_id_ff;
   logic                          accept;

   // take a new transaction when empty or when the held one leaves
   assign req_ch.ready = !valid_ff || pop;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold payload until replaced
   always_ff @(posedge clock) begin
      if (accept) begin
         command_ff    <= req_ch.command;
         package_id_ff <= req_ch.package_id;
      end
   end

   assign item.valid      = valid_ff;
   assign item.command    = command_ff;
   assign item.package_id = package_id_ff;

endmodule

### hdl/bcc_belt.sv
// Belt state (slot valid bits, ids, length, count) and the one-pass update
// for insert, advance and retrieve. Depends on bcc_pkg.
module bcc_belt (
   input  logic                            clock,
   input  logic                            reset,
   input  bcc_pkg::item_type               item,
   input  logic                            fire,
   input  logic                            csr_we,
   input  logic [bcc_pkg::LEN_WIDTH-1:0]   csr_wdata,
   output bcc_pkg::result_type             result
);

   localparam int N = bcc_pkg::MAX_SLOTS;

   logic [bcc_pkg::LEN_WIDTH-1:0]      len_ff, len_in;
   logic [N-1:0]                       valid_ff, valid_in, step_valid;
   logic [bcc_pkg::ID_WIDTH-1:0]       id_ff [N];
   logic [bcc_pkg::ID_WIDTH-1:0]       id_in [N];
   logic [bcc_pkg::COUNT_WIDTH-1:0]    count_ff, count_in, step_count;
   logic [bcc_pkg::SLOT_IDX_WIDTH-1:0] exit_idx;
   logic [N:0]                         valid_ext;
   logic [N:0]                         move_ext;
   logic [N-1:0]                       len_mask;
   logic                               cfg_ok;
   logic                               success;
   logic [bcc_pkg::ID_WIDTH-1:0]       got_id;

   assign exit_idx  = bcc_pkg::SLOT_IDX_WIDTH'(len_ff - bcc_pkg::LEN_WIDTH'(1));
   assign valid_ext = {1'b0, valid_ff};
   assign cfg_ok    = csr_we && (csr_wdata != '0)
                      && (int'(csr_wdata) <= bcc_pkg::MAX_SLOTS);

   // slots in use
   always_comb begin
      for (int i = 0; i < N; i++) begin
         len_mask[i] = (i < int'(len_ff));
      end
   end

   // move chain from the exit toward the entry: a slot moves if the next slot
   // is empty or is itself moving, and the next slot lies inside the belt
   always_comb begin
      move_ext[N] = 1'b0;
      for (int i = N - 1; i >= 0; i--) begin
         move_ext[i] = (i + 1 < int'(len_ff)) && valid_ext[i]
                       && (!valid_ext[i+1] || move_ext[i+1]);
      end
   end

   // apply the command
   always_comb begin
      step_valid = valid_ff;
      step_count = count_ff;
      id_in      = id_ff;
      success    = 1'b0;
      got_id     = '0;
      if (fire) begin
         unique case (item.command)
            bcc_pkg::CMD_INSERT: begin
               if (!valid_ff[0]) begin
                  step_valid[0] = 1'b1;
                  id_in[0]      = item.package_id;
                  step_count    = count_ff + bcc_pkg::COUNT_WIDTH'(1);
                  success       = 1'b1;
               end
            end
            bcc_pkg::CMD_ADVANCE: begin
               step_valid[0] = valid_ff[0] && !move_ext[0];
               for (int i = 1; i < N; i++) begin
                  step_valid[i] = (valid_ff[i] && !move_ext[i]) || move_ext[i-1];
                  if (move_ext[i-1]) begin
                     id_in[i] = id_ff[i-1];
                  end
               end
               success = |move_ext[N-1:0];
            end
            bcc_pkg::CMD_RETRIEVE: begin
               if (valid_ff[exit_idx]) begin
                  step_valid[exit_idx] = 1'b0;
                  got_id               = id_ff[exit_idx];
                  step_count           = count_ff - bcc_pkg::COUNT_WIDTH'(1);
                  success              = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // a length write of 1 to MAX_SLOTS empties the belt; other values are ignored
   always_comb begin
      len_in   = len_ff;
      valid_in = step_valid;
      count_in = step_count;
      if (cfg_ok) begin
         len_in   = csr_wdata;
         valid_in = '0;
         count_in = '0;
      end
   end

   assign result.success        = success;
   assign result.retrieved_id   = got_id;
   assign result.exit_occupied  = step_valid[exit_idx];
   assign result.occupied_count = step_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= bcc_pkg::LEN_WIDTH'(bcc_pkg::RESET_LENGTH);
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         len_ff   <= len_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   // running count tracks the valid bits
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == bcc_pkg::COUNT_WIDTH'($countones(valid_ff)))
      else $error("occupancy count out of step with slot valid bits");

   // nothing occupies a slot past the exit
   a_no_slot_past_exit: assert property (@(posedge clock) disable iff (reset)
      (valid_ff & ~len_mask) == '0)
      else $error("slot beyond belt length is occupied");

   // advance keeps the number of packages
   a_advance_keeps_count: assert property (@(posedge clock) disable iff (reset)
      fire && (item.command == bcc_pkg::CMD_ADVANCE) && !csr_we
      |=> count_ff == $past(count_ff))
      else $error("advance changed occupancy count");

   // insert without a length write always leaves the entry occupied
   a_insert_fills_entry: assert property (@(posedge clock) disable iff (reset)
      fire && (item.command == bcc_pkg::CMD_INSERT) && !csr_we |=> valid_ff[0])
      else $error("entry slot empty after insert");

endmodule

### hdl/bcc_output_stage.sv
// Result register of the conveyor: holds one response transaction.
// Depends on bcc_pkg and bcc_rsp_if.
module bcc_output_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bcc_pkg::result_type result,
   output logic                can_push,
   bcc_rsp_if.source           rsp_ch
);

   logic                valid_ff, valid_in;
   bcc_pkg::result_type result_ff;

   // room when empty or when the held result is taken now
   assign can_push = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.success        = result_ff.success;
   assign rsp_ch.retrieved_id   = result_ff.retrieved_id;
   assign rsp_ch.exit_occupied  = result_ff.exit_occupied;
   assign rsp_ch.occupied_count = result_ff.occupied_count;

endmodule
